FILE: src/cts_pkg.sv
// Package: widths and constants for the cycle count to timestamp converter.
`default_nettype none
package cts_pkg;
	localparam int unsigned CountW   = 32;
	localparam int unsigned ExtW     = 2 * CountW;
	localparam int unsigned MhzW     = 10;
	localparam int unsigned SecW     = 45;
	localparam int unsigned FracW    = 10;
	localparam int unsigned StepW    = $clog2(ExtW);
	localparam logic [MhzW-1:0]  MhzReset = MhzW'(168);
	localparam logic [MhzW-1:0]  MhzOne   = MhzW'(1);
	localparam logic [FracW-1:0] Thousand = FracW'(1000);
	localparam logic [StepW-1:0] LastStep = StepW'(ExtW - 1);
endpackage
`default_nettype wire

FILE: src/cts_if.sv
// Interfaces: sample beat channel and timestamp beat channel.
`default_nettype none
interface cts_in_if import cts_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CountW-1:0] cycle_count;
	modport source (output valid, output cycle_count, input ready);
	modport sink   (input valid, input cycle_count, output ready);
endinterface

interface cts_out_if import cts_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SecW-1:0]  seconds;
	logic [FracW-1:0] milliseconds;
	logic [FracW-1:0] microseconds;
	logic [ExtW-1:0]  total_us;
	logic             wrapped;
	modport source (output valid, output seconds, output milliseconds, output microseconds,
		output total_us, output wrapped, input ready);
	modport sink   (input valid, input seconds, input milliseconds, input microseconds,
		input total_us, input wrapped, output ready);
endinterface
`default_nettype wire

FILE: src/cts_extend.sv
// Counter extension: tracks last sample and wrap count, flags wraps.
`default_nettype none
module cts_extend import cts_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire logic [CountW-1:0] sample,
	output logic                   wrap,
	output logic [CountW-1:0]      wrap_next
);
	logic [CountW-1:0] last_q;
	logic [CountW-1:0] wraps_q;

	assign wrap      = sample < last_q;
	assign wrap_next = wraps_q + CountW'(wrap);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			wraps_q <= '0;
		end else if (load) begin
			last_q  <= sample;
			wraps_q <= wrap_next;
		end
	end
endmodule
`default_nettype wire

FILE: src/cts_div_cell.sv
// Bit-serial restoring divide cell: one dividend bit in, one quotient bit out per cycle while en is high.
`default_nettype none
module cts_div_cell import cts_pkg::*; #(
	parameter int unsigned DivW = FracW
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            clr,
	input  wire logic            en,
	input  wire logic            din,
	input  wire logic [DivW-1:0] divisor,
	output logic                 qbit,
	output logic [DivW-1:0]      rem
);
	logic [DivW-1:0] rem_q;
	logic [DivW:0]   trial;
	logic [DivW:0]   diff;

	assign trial = {rem_q, din};
	assign diff  = trial - {1'b0, divisor};
	assign qbit  = trial >= {1'b0, divisor};
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (clr) begin
			rem_q <= '0;
		end else if (en) begin
			rem_q <= qbit ? diff[DivW-1:0] : trial[DivW-1:0];
		end
	end
endmodule
`default_nettype wire

FILE: src/cycle_count_to_timestamp_core.sv
// Top level: cycle counter extension and conversion to seconds / ms / us.
//
//  channel    dir  handshake     beat contents
//  cfg        in   cfg_we        cfg_wdata = clock_mhz
//  sample_ch  in   valid/ready   cycle_count
//  result_ch  out  valid/ready   seconds, milliseconds, microseconds, total_us, wrapped
//
// Each sample is taken as a beat, passed through the bit-serial divide
// chain (count / mhz -> total_us, then / 1000 twice), then loaded into the output register.
// The chain is fed the 64-bit extended count one bit per cycle.
// Reset sets clock_mhz to 168 and clears last sample and wrap count.
// A new sample is taken while the previous result waits on result_ch.ready.
`default_nettype none
module cycle_count_to_timestamp_core import cts_pkg::*; (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [MhzW-1:0] cfg_wdata,
	cts_in_if.sink               sample_ch,
	cts_out_if.source            result_ch
);
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_FIN  = 3'b100
	} cts_state_t;

	cts_state_t        state_q;
	logic [MhzW-1:0]   mhz_q;
	logic [MhzW-1:0]   divisor;
	logic [StepW-1:0]  step_q;
	logic [ExtW-1:0]   count_q;
	logic [ExtW-1:0]   total_q;
	logic [SecW-1:0]   secs_q;
	logic              wrap_q;
	logic              take;
	logic              run;
	logic              wrap;
	logic [CountW-1:0] wrap_next;
	logic              qa;
	logic              qb;
	logic              qc;
	logic [FracW-1:0]  us_rem;
	logic [FracW-1:0]  ms_rem;
	logic [MhzW-1:0]   mhz_rem;
	logic              out_valid_q;
	logic              out_free;

	assign divisor         = (mhz_q == '0) ? MhzOne : mhz_q;
	assign sample_ch.ready = state_q == ST_IDLE;
	assign take            = sample_ch.valid && sample_ch.ready;
	assign run             = state_q == ST_RUN;
	assign out_free        = !out_valid_q || result_ch.ready;
	assign result_ch.valid = out_valid_q;

	cts_extend u_extend (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.sample    (sample_ch.cycle_count),
		.wrap      (wrap),
		.wrap_next (wrap_next)
	);

	// count / mhz -> total_us
	cts_div_cell #(.DivW(MhzW)) u_div_us (
		.clk (clk), .arst_n (arst_n), .clr (take), .en (run),
		.din (count_q[ExtW-1]), .divisor (divisor), .qbit (qa), .rem (mhz_rem)
	);

	// total_us / 1000 -> microseconds remainder
	cts_div_cell #(.DivW(FracW)) u_div_ms (
		.clk (clk), .arst_n (arst_n), .clr (take), .en (run),
		.din (qa), .divisor (Thousand), .qbit (qb), .rem (us_rem)
	);

	// total_ms / 1000 -> seconds, milliseconds remainder
	cts_div_cell #(.DivW(FracW)) u_div_s (
		.clk (clk), .arst_n (arst_n), .clr (take), .en (run),
		.din (qb), .divisor (Thousand), .qbit (qc), .rem (ms_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mhz_q <= MhzReset;
		end else if (cfg_we) begin
			mhz_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_RUN;
						step_q  <= '0;
					end
				end
				ST_RUN: begin
					step_q <= step_q + StepW'(1);
					if (step_q == LastStep) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			count_q <= {wrap_next, sample_ch.cycle_count};
			wrap_q  <= wrap;
		end else if (run) begin
			count_q <= {count_q[ExtW-2:0], 1'b0};
			total_q <= {total_q[ExtW-2:0], qa};
			secs_q  <= {secs_q[SecW-2:0], qc};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			result_ch.seconds      <= secs_q;
			result_ch.milliseconds <= ms_rem;
			result_ch.microseconds <= us_rem;
			result_ch.total_us     <= total_q;
			result_ch.wrapped      <= wrap_q;
		end
	end

	// sub-microsecond cycles are dropped
	logic unused_rem;
	assign unused_rem = ^mhz_rem;
endmodule
`default_nettype wire
